// ----- design/spa_pkg.sv -----
// Shared constants, types and step functions for the sphere projected area pipeline.
package spa_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FW         = 2 * FRAC_BITS;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int NUM_REGS   = 7;

    localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] EPS_Q   = ((64'd1 << FW) + 64'd99999) / 64'd100000;
    localparam logic [31:0] PI4_Q32 = 32'd3373259426;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ROW0_A = 3'd0;
    localparam logic [2:0] REG_ROW0_B = 3'd1;
    localparam logic [2:0] REG_ROW1_A = 3'd2;
    localparam logic [2:0] REG_ROW1_B = 3'd3;
    localparam logic [2:0] REG_ROW2_A = 3'd4;
    localparam logic [2:0] REG_ROW2_B = 3'd5;
    localparam logic [2:0] REG_COT    = 3'd6;

    // Outcome codes
    localparam logic [2:0] OUT_NO_RADIUS = 3'd0;
    localparam logic [2:0] OUT_BEHIND    = 3'd1;
    localparam logic [2:0] OUT_INSIDE    = 3'd2;
    localparam logic [2:0] OUT_DEGEN     = 3'd3;
    localparam logic [2:0] OUT_COMPUTED  = 3'd4;

    typedef struct packed {
        logic [2:0] outcome;
        logic       sat;
    } meta_t;

    // One restoring division step: returns {remainder, shifted dividend with quotient bit}
    function automatic logic [127:0] div_step(input logic [63:0] r, input logic [63:0] w,
                                              input logic [63:0] d);
        logic [64:0] t;
        logic        ge;
        t  = {r, w[63]};
        ge = (t >= {1'b0, d});
        if (ge) begin
            t = t - {1'b0, d};
        end
        return {t[63:0], w[62:0], ge};
    endfunction

    // One digit of the integer square root: returns {remainder, root}
    function automatic logic [127:0] sqrt_step(input logic [63:0] v, input logic [63:0] res,
                                               input logic [63:0] bitv);
        logic [63:0] trial;
        logic [63:0] v_n;
        logic [63:0] res_n;
        trial = res + bitv;
        if (v >= trial) begin
            v_n   = v - trial;
            res_n = (res >> 1) + bitv;
        end else begin
            v_n   = v;
            res_n = res >> 1;
        end
        return {v_n, res_n};
    endfunction

endpackage

// ----- design/spa_front.sv -----
// View transform, classification, squares and dividend setup (five stages).
module spa_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic [5:0][63:0]      view_rows,
    input  logic [31:0]           cot,
    input  logic                  in_valid,
    input  logic signed [31:0]    cx,
    input  logic signed [31:0]    cy,
    input  logic signed [31:0]    cz,
    input  logic signed [31:0]    radius,
    output logic                  out_valid,
    output spa_pkg::meta_t        out_meta,
    output logic [63:0]           hi0,
    output logic [63:0]           lo0,
    output logic [63:0]           hi1,
    output logic [63:0]           lo1,
    output logic [63:0]           den
);
    import spa_pkg::*;

    localparam logic signed [65:0] VMAX = 66'sd2147483647;
    localparam logic signed [65:0] VMIN = -66'sd2147483648;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [63:0] prod_reg [0:2][0:2];
    logic signed [31:0] r1_reg, r2_reg;
    logic signed [31:0] view_reg [0:2];
    logic signed [65:0] sum_c [0:2];
    logic signed [31:0] view_next [0:2];
    logic [2:0]        oc3_next, oc3_reg, oc4_reg, oc5_reg;
    logic [63:0]       rr_reg, xx_reg, yy_reg, zz_reg;
    logic [31:0]       mx, my, mz, mr;
    logic [63:0]       k_reg;
    logic [63:0]       e_next, n_next;
    logic [63:0]       e_reg, n_reg;
    logic [63:0]       pll_reg, plh_reg, phl_reg, phh_reg;
    logic [127:0]      kr;
    logic signed [32:0] near_sum;

    // Hold cot squared; configuration must only change while idle, which the block itself does not enforce
    always_ff @(posedge aclk) begin
        k_reg <= 64'(cot) * 64'(cot);
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: matrix products
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i][0] <= $signed(view_rows[2*i][31:0]) * cx;
                prod_reg[i][1] <= $signed(view_rows[2*i][63:32]) * cy;
                prod_reg[i][2] <= $signed(view_rows[2*i+1][31:0]) * cz;
            end
            r1_reg <= radius;
        end
    end

    // Stage 2: floor, sum with translation, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_c[i] = 66'(prod_reg[i][0] >>> FRAC_BITS) + 66'(prod_reg[i][1] >>> FRAC_BITS)
                     + 66'(prod_reg[i][2] >>> FRAC_BITS)
                     + (66'($signed(view_rows[2*i+1][63:32])) <<< FRAC_BITS);
            if (sum_c[i] > VMAX) begin
                view_next[i] = 32'sh7FFFFFFF;
            end else if (sum_c[i] < VMIN) begin
                view_next[i] = 32'sh80000000;
            end else begin
                view_next[i] = sum_c[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                view_reg[i] <= view_next[i];
            end
            r2_reg <= r1_reg;
        end
    end

    // Stage 3: classify and square
    assign near_sum = 33'(view_reg[2]) + 33'(r2_reg);

    always_comb begin
        if (r2_reg <= 32'sd0) begin
            oc3_next = OUT_NO_RADIUS;
        end else if (view_reg[2] > 32'sd0) begin
            oc3_next = (view_reg[2] > r2_reg) ? OUT_BEHIND : OUT_INSIDE;
        end else if (near_sum > 33'sd0) begin
            oc3_next = OUT_INSIDE;
        end else begin
            oc3_next = OUT_COMPUTED;
        end
        mx = view_reg[0][31] ? (~view_reg[0] + 32'd1) : view_reg[0];
        my = view_reg[1][31] ? (~view_reg[1] + 32'd1) : view_reg[1];
        mz = view_reg[2][31] ? (~view_reg[2] + 32'd1) : view_reg[2];
        mr = r2_reg[31] ? (~r2_reg + 32'd1) : r2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oc3_reg <= oc3_next;
            xx_reg  <= 64'(mx) * 64'(mx);
            yy_reg  <= 64'(my) * 64'(my);
            zz_reg  <= 64'(mz) * 64'(mz);
            rr_reg  <= 64'(mr) * 64'(mr);
        end
    end

    // Stage 4: differences, small-denominator check, partial products of K*R
    assign e_next = zz_reg - rr_reg;
    assign n_next = xx_reg + yy_reg + zz_reg - rr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            oc4_reg <= (oc3_reg == OUT_COMPUTED && e_next < EPS_Q) ? OUT_DEGEN : oc3_reg;
            e_reg   <= e_next;
            n_reg   <= n_next;
            pll_reg <= 64'(k_reg[31:0])  * 64'(rr_reg[31:0]);
            plh_reg <= 64'(k_reg[31:0])  * 64'(rr_reg[63:32]);
            phl_reg <= 64'(k_reg[63:32]) * 64'(rr_reg[31:0]);
            phh_reg <= 64'(k_reg[63:32]) * 64'(rr_reg[63:32]);
        end
    end

    // Stage 5: combine partial products, set up both dividends
    assign kr = {phh_reg, 64'd0} + {32'd0, phl_reg, 32'd0} + {32'd0, plh_reg, 32'd0}
              + {64'd0, pll_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            oc5_reg <= oc4_reg;
            hi0     <= n_reg >> (64 - FW);
            lo0     <= n_reg << FW;
            hi1     <= kr[127:64];
            lo1     <= kr[63:0];
            den     <= e_reg;
        end
    end

    assign out_valid        = v5_reg;
    assign out_meta.outcome = oc5_reg;
    assign out_meta.sat     = 1'b0;

endmodule

// ----- design/spa_div.sv -----
// Two-lane restoring divider sharing one divisor, one quotient bit per stage.
module spa_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  spa_pkg::meta_t  in_meta,
    input  logic [63:0]     hi0,
    input  logic [63:0]     lo0,
    input  logic [63:0]     hi1,
    input  logic [63:0]     lo1,
    input  logic [63:0]     den,
    output logic            out_valid,
    output spa_pkg::meta_t  out_meta,
    output logic [63:0]     quo0,
    output logic [63:0]     quo1
);
    import spa_pkg::*;

    logic        vld_reg  [0:DIV_STEPS];
    meta_t       meta_reg [0:DIV_STEPS];
    logic [63:0] d_reg    [0:DIV_STEPS];
    logic [63:0] r_reg    [0:DIV_STEPS][0:1];
    logic [63:0] w_reg    [0:DIV_STEPS][0:1];

    // Load stage: flag quotients that exceed 64 bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta_reg[0].outcome <= in_meta.outcome;
            meta_reg[0].sat     <= in_meta.sat | (hi0 >= den) | (hi1 >= den);
            d_reg[0]            <= den;
            r_reg[0][0]         <= hi0;
            w_reg[0][0]         <= lo0;
            r_reg[0][1]         <= hi1;
            w_reg[0][1]         <= lo1;
        end
    end

    // One quotient bit per stage in each lane
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [127:0] st0, st1;

        assign st0 = div_step(r_reg[g][0], w_reg[g][0], d_reg[g]);
        assign st1 = div_step(r_reg[g][1], w_reg[g][1], d_reg[g]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                meta_reg[g+1]  <= meta_reg[g];
                d_reg[g+1]     <= d_reg[g];
                r_reg[g+1][0]  <= st0[127:64];
                w_reg[g+1][0]  <= st0[63:0];
                r_reg[g+1][1]  <= st1[127:64];
                w_reg[g+1][1]  <= st1[63:0];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_meta  = meta_reg[DIV_STEPS];
    assign quo0      = w_reg[DIV_STEPS][0];
    assign quo1      = w_reg[DIV_STEPS][1];

endmodule

// ----- design/spa_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module spa_sqrt (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  spa_pkg::meta_t  in_meta,
    input  logic [63:0]     radicand,
    input  logic [63:0]     in_a,
    output logic            out_valid,
    output spa_pkg::meta_t  out_meta,
    output logic [31:0]     root,
    output logic [63:0]     out_a
);
    import spa_pkg::*;

    logic        vld_reg  [0:SQRT_STEPS];
    meta_t       meta_reg [0:SQRT_STEPS];
    logic [63:0] v_reg    [0:SQRT_STEPS];
    logic [63:0] res_reg  [0:SQRT_STEPS];
    logic [63:0] a_reg    [0:SQRT_STEPS];

    // Stage inputs
    always_comb begin
        vld_reg[0]  = in_valid;
        meta_reg[0] = in_meta;
        v_reg[0]    = radicand;
        res_reg[0]  = 64'd0;
        a_reg[0]    = in_a;
    end

    // Resolve one root bit per stage, highest first
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * g);
        logic [127:0] st;

        assign st = sqrt_step(v_reg[g], res_reg[g], BITV);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                meta_reg[g+1] <= meta_reg[g];
                v_reg[g+1]    <= st[127:64];
                res_reg[g+1]  <= st[63:0];
                a_reg[g+1]    <= a_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign out_meta  = meta_reg[SQRT_STEPS];
    assign root      = res_reg[SQRT_STEPS][31:0];
    assign out_a     = a_reg[SQRT_STEPS];

endmodule

// ----- design/spa_back.sv -----
// Final products, saturation and outcome selection into the output register.
module spa_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  spa_pkg::meta_t  in_meta,
    input  logic [63:0]     in_a,
    input  logic [31:0]     root,
    output logic            out_valid,
    output logic [31:0]     coverage,
    output logic [2:0]      outcome,
    output logic            saturated
);
    import spa_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    meta_t       m1_reg, m2_reg, m3_reg;
    logic [63:0] pl_reg, ph_reg, b_reg, cl_reg, ch_reg;
    logic [95:0] p;
    logic [63:0] c;
    logic        sat_c;
    logic [31:0] cov_c;

    // Advance valid bits; the last one is the output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // A * S partial products
    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg <= in_meta;
            pl_reg <= 64'(in_a[31:0]) * 64'(root);
            ph_reg <= 64'(in_a[63:32]) * 64'(root);
        end
    end

    // Combine and shift to B
    assign p = {ph_reg, 32'd0} + {32'd0, pl_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_reg.outcome <= m1_reg.outcome;
            m2_reg.sat     <= m1_reg.sat | ((p >> (64 + FW)) != 96'd0);
            b_reg          <= 64'(p >> FW);
        end
    end

    // B * pi/4 partial products
    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_reg <= m2_reg;
            cl_reg <= 64'(b_reg[31:0]) * 64'(PI4_Q32);
            ch_reg <= 64'(b_reg[63:32]) * 64'(PI4_Q32);
        end
    end

    // Pick the coverage by outcome, clamp computed values
    assign c     = ch_reg + {32'd0, cl_reg[63:32]};
    assign sat_c = m3_reg.sat | (c[63:32] != 32'd0);

    always_comb begin
        unique case (m3_reg.outcome)
            OUT_NO_RADIUS, OUT_BEHIND: cov_c = 32'd0;
            OUT_INSIDE, OUT_DEGEN:     cov_c = ONE_Q[31:0];
            OUT_COMPUTED:              cov_c = sat_c ? 32'hFFFFFFFF : c[31:0];
            default:                   cov_c = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            coverage  <= cov_c;
            outcome   <= m3_reg.outcome;
            saturated <= (m3_reg.outcome == OUT_COMPUTED) && sat_c;
        end
    end

    assign out_valid = v4_reg;

endmodule

// ----- design/sphere_projected_area.sv -----
// Top level of the sphere projected area pipeline with its configuration registers.
//
// One sphere enters per clock while the pipeline advances. Each sphere passes
// through the view transform, squares and setup, then the shared-divisor
// divider (one quotient bit per stage for both N/E and K*R/E), then the square
// root (one root bit per stage) and last the final products and output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so s_tready follows that condition and nothing is lost or
// repeated under backpressure. Write the view matrix and cot(fovY/2) only while
// no transaction is in flight.
module sphere_projected_area (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_addr,
    input  logic [63:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // center_x, center_y, center_z, radius
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // coverage
    output logic [3:0]    m_tuser    // outcome, saturated
);
    import spa_pkg::*;

    logic [5:0][63:0] view_reg;
    logic [31:0]      cot_reg;
    logic             adv;
    logic             f_valid, d_valid, q_valid;
    meta_t            f_meta, d_meta, q_meta;
    logic [63:0]      hi0, lo0, hi1, lo1, den;
    logic [63:0]      quo0, quo1, q_a;
    logic [31:0]      root;
    logic [2:0]       outcome;
    logic             saturated;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_reg[REG_ROW0_A] <= ONE_Q;
            view_reg[REG_ROW0_B] <= 64'd0;
            view_reg[REG_ROW1_A] <= ONE_Q << 32;
            view_reg[REG_ROW1_B] <= 64'd0;
            view_reg[REG_ROW2_A] <= 64'd0;
            view_reg[REG_ROW2_B] <= ONE_Q;
            cot_reg              <= ONE_Q[31:0];
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_COT) begin
                cot_reg <= cfg_wdata[31:0];
            end else if (cfg_addr < REG_COT) begin
                view_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    // Advance the pipeline when the output register can move
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    spa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .view_rows (view_reg),
        .cot       (cot_reg),
        .in_valid  (s_tvalid),
        .cx        ($signed(s_tdata[31:0])),
        .cy        ($signed(s_tdata[63:32])),
        .cz        ($signed(s_tdata[95:64])),
        .radius    ($signed(s_tdata[127:96])),
        .out_valid (f_valid),
        .out_meta  (f_meta),
        .hi0       (hi0),
        .lo0       (lo0),
        .hi1       (hi1),
        .lo1       (lo1),
        .den       (den)
    );

    spa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_meta   (f_meta),
        .hi0       (hi0),
        .lo0       (lo0),
        .hi1       (hi1),
        .lo1       (lo1),
        .den       (den),
        .out_valid (d_valid),
        .out_meta  (d_meta),
        .quo0      (quo0),
        .quo1      (quo1)
    );

    spa_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_valid),
        .in_meta   (d_meta),
        .radicand  (quo0),
        .in_a      (quo1),
        .out_valid (q_valid),
        .out_meta  (q_meta),
        .root      (root),
        .out_a     (q_a)
    );

    spa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_meta   (q_meta),
        .in_a      (q_a),
        .root      (root),
        .out_valid (m_tvalid),
        .coverage  (m_tdata),
        .outcome   (outcome),
        .saturated (saturated)
    );

    assign m_tuser = {saturated, outcome};

endmodule

// ----- verif/sphere_projected_area_test.sv -----
// Self-checking testbench for the sphere projected area pipeline.
`timescale 1ns / 1ps

module sphere_projected_area_test;
    import spa_pkg::*;

    localparam int LATENCY     = 106;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] coverage;
        logic [2:0]  outcome;
        logic        saturated;
    } coverage_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [2:0]    cfg_addr;
    logic [63:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [31:0]   m_tdata;
    logic [3:0]    m_tuser;

    logic [63:0] view_regs [NUM_REGS];
    coverage_t   pending_coverage [$];
    int          mismatch_count;
    int          cycle_count;
    int          stall_left;
    bit          idle_enable;

    sphere_projected_area DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Generate clock and bound the run
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Saturating view coordinate from one matrix row
    function automatic logic signed [63:0] view_coord(input int row,
            input logic signed [31:0] cx, input logic signed [31:0] cy,
            input logic signed [31:0] cz);
        logic signed [63:0] sum;
        logic [63:0] ra;
        logic [63:0] rb;
        ra  = view_regs[row * 2];
        rb  = view_regs[row * 2 + 1];
        sum = (($signed(ra[31:0]) * 64'(cx)) >>> FRAC_BITS)
            + (($signed(ra[63:32]) * 64'(cy)) >>> FRAC_BITS)
            + (($signed(rb[31:0]) * 64'(cz)) >>> FRAC_BITS)
            + (64'($signed(rb[63:32])) <<< FRAC_BITS);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum;
    endfunction

    // floor(a*b/d) with saturation at 64 bits
    function automatic logic [63:0] scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                                    input logic [63:0] d, inout bit sat);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = 128'(a) * 128'(b);
        quo  = prod / 128'(d);
        if (quo[127:64] != 0) begin
            sat = 1'b1;
            return '1;
        end
        return quo[63:0];
    endfunction

    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int sh, inout bit sat);
        logic [127:0] prod;
        prod = (128'(a) * 128'(b)) >> sh;
        if (prod[127:64] != 0) begin
            sat = 1'b1;
            return '1;
        end
        return prod[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (128'(trial) * 128'(trial) <= 128'(v)) root = trial;
        end
        return root;
    endfunction

    // Predict the coverage result of one sphere
    function automatic coverage_t predict_coverage(input logic [127:0] sphere);
        coverage_t res;
        logic signed [31:0] cx, cy, cz, r;
        logic signed [63:0] vx, vy, vz, r64;
        logic [63:0] rr, zz, dd, e, n, q, s, k, a, b, c;
        bit sat;
        cx  = sphere[31:0];
        cy  = sphere[63:32];
        cz  = sphere[95:64];
        r   = sphere[127:96];
        res = '0;
        sat = 1'b0;
        if (r <= 0) begin
            res.outcome = OUT_NO_RADIUS;
            return res;
        end
        r64 = 64'(r);
        vx  = view_coord(0, cx, cy, cz);
        vy  = view_coord(1, cx, cy, cz);
        vz  = view_coord(2, cx, cy, cz);
        if (vz > 0) begin
            if (vz > r64) begin
                res.outcome = OUT_BEHIND;
            end else begin
                res.coverage = ONE_Q[31:0];
                res.outcome  = OUT_INSIDE;
            end
            return res;
        end
        if (-vz < r64) begin
            res.coverage = ONE_Q[31:0];
            res.outcome  = OUT_INSIDE;
            return res;
        end
        rr = r64 * r64;
        zz = vz * vz;
        dd = vx * vx + vy * vy + zz;
        e  = zz - rr;
        if (e < EPS_Q) begin
            res.coverage = ONE_Q[31:0];
            res.outcome  = OUT_DEGEN;
            return res;
        end
        n = dd - rr;
        q = scaled_quotient(n, 64'd1 << FW, e, sat);
        s = int_sqrt(q);
        k = 64'(view_regs[REG_COT][31:0]) * 64'(view_regs[REG_COT][31:0]);
        a = scaled_quotient(k, rr, e, sat);
        b = scaled_product(a, s, FW, sat);
        c = scaled_product(b, 64'(PI4_Q32), 32, sat);
        if (c[63:32] != 0) sat = 1'b1;
        res.coverage  = sat ? 32'hFFFFFFFF : c[31:0];
        res.outcome   = OUT_COMPUTED;
        res.saturated = sat;
        return res;
    endfunction

    // Receiver: stall at random, compare each transaction with the oldest prediction
    always @(posedge aclk) begin
        coverage_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_coverage.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result %h %h", m_tdata, m_tuser);
                end else begin
                    want = pending_coverage.pop_front();
                    if (m_tdata !== want.coverage || m_tuser[2:0] !== want.outcome ||
                        m_tuser[3] !== want.saturated) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected cov %h out %0d sat %0d, got %h %0d %0d",
                                     want.coverage, want.outcome, want.saturated,
                                     m_tdata, m_tuser[2:0], m_tuser[3]);
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_enable && m_tready && $urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        view_regs[idx] = (idx == REG_COT) ? {32'd0, value[31:0]} : value;
        @(posedge aclk);
    endtask

    // Send one sphere and record its prediction
    task automatic send_sphere(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input logic [31:0] r);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, cz, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_coverage.push_back(predict_coverage({r, cz, cy, cx}));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_coverage.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_fixed();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000FFFFF);
            2: return -$urandom_range(0, 32'h000FFFFF);
            default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    // Directed: field extremes and every outcome under the reset matrix
    task automatic test_directed();
        send_sphere(0, 0, -32'sd655360, 0);
        send_sphere(0, 0, -32'sd655360, 32'h80000000);
        send_sphere(0, 0, 32'sd655360, 32'sd65536);
        send_sphere(0, 0, 32'sd32768, 32'sd65536);
        send_sphere(0, 0, -32'sd32768, 32'sd65536);
        send_sphere(0, 0, -32'sd65536, 32'sd65536);
        send_sphere(0, 0, -32'sd655360, 32'sd65536);
        send_sphere(32'sd655360, -32'sd655360, -32'sd655360, 32'sd65536);
        send_sphere(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1);
        send_sphere(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_sphere(0, 0, -32'sd65537, 32'sd65536);
        send_sphere(0, 0, -32'sd6553600, 32'sd6553599);
        send_sphere(0, 0, -32'sd65536, 1);
        drain_pipeline();
    endtask

    // Registers at extremes: narrow FOV, zero cot, saturating matrix
    task automatic test_register_extremes();
        write_reg(REG_COT, 64'hFFFFFFFF);
        for (int i = 0; i < 6; i++) send_sphere(rand_fixed(), rand_fixed(), rand_fixed(),
                                                $urandom_range(1, 32'h00FFFFFF));
        drain_pipeline();
        write_reg(REG_COT, 0);
        for (int i = 0; i < 4; i++) send_sphere(rand_fixed(), rand_fixed(), -32'sd6553600,
                                                32'sd65536);
        drain_pipeline();
        for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), '1);
        for (int i = 0; i < 6; i++) send_sphere($urandom, $urandom, $urandom, $urandom);
        drain_pipeline();
        for (int i = 0; i < 6; i++) write_reg(3'(i), 64'h7FFFFFFF_80000000);
        write_reg(REG_COT, 64'h00010000);
        for (int i = 0; i < 6; i++) send_sphere($urandom, $urandom, $urandom, $urandom);
        drain_pipeline();
    endtask

    // Random matrices and spheres
    task automatic test_random(input int phases, input int per_phase);
        logic [31:0] r;
        for (int p = 0; p < phases; p++) begin
            for (int i = 0; i < 6; i++)
                write_reg(3'(i), ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                                 {rand_fixed(), rand_fixed()});
            write_reg(REG_COT, ($urandom_range(0, 3) == 0) ? $urandom :
                               $urandom_range(32'h00004000, 32'h00080000));
            for (int i = 0; i < per_phase; i++) begin
                r = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32'h000FFFFF);
                send_sphere(rand_fixed(), rand_fixed(), rand_fixed(), r);
            end
            drain_pipeline();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        stall_left     = 0;
        idle_enable    = 1'b1;
        view_regs[0] = 64'd65536;           view_regs[1] = 0;
        view_regs[2] = 64'd281474976710656; view_regs[3] = 0;
        view_regs[4] = 0;                   view_regs[5] = 64'd65536;
        view_regs[6] = 64'd65536;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_extremes();
        test_random(8, 150);
        idle_enable = 1'b0;
        test_random(2, 100);
        drain_pipeline();
        if (mismatch_count == 0 && pending_coverage.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
